// ----- design/tbet_pkg.sv -----
// Shared types and constants for the touch button event tracker.
// No dependencies; imported by every module of the block.
package tbet_pkg;

    localparam int NUM_PADS = 16;
    localparam int PAD_W    = 4;
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 24;
    localparam int CNT_W    = 8;
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    localparam logic [CNT_W-1:0] WINDOW_RESET = CNT_W'(100);

    typedef enum logic [1:0] {
        BTN_IDLE     = 2'd0,
        BTN_KEY_DOWN = 2'd1,
        BTN_KEY_UP   = 2'd2,
        BTN_CLICK    = 2'd3
    } btn_t;

    // One pad's record in the state memory
    typedef struct packed {
        logic [SAMPLE_W-1:0] threshold;
        logic [SUM_W-1:0]    sum;
        logic [CNT_W-1:0]    count;
        btn_t                btn;
    } entry_t;

endpackage

// ----- design/touch_button_event_tracker_core.sv -----
// Touch button event tracker: top level with sequencer and output register.
// Depends on tbet_pkg, tbet_state_mem and tbet_div.
//
// Per-pad thresholds, calibration sums and button states sit in a 16-entry
// state memory with a registered read; it reads as zero after reset, so no
// clearing pass is needed. One word is processed at a time: accept (reading
// the pad's entry), ST_READ to evaluate and write back, then ST_OUT offers
// each event word until the sink takes it. A sample that closes a calibration
// window runs the 24-step divider in ST_DIV before the write-back.
// calib_window is to be written by the user through cfg_valid/cfg_data only
// while the block is idle; the block itself does not enforce this.
module touch_button_event_tracker_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,    // calib_window
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,     // [3:0] pad, [19:4] sample, rest zero
    input  logic        s_tuser,     // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [3:0] event_pad, rest zero
    output logic [1:0]  m_tuser,     // event_kind
    output logic        m_tlast
);
    import tbet_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     window_reg, window_next;
    logic                 cmd_reg, cmd_next;
    logic [PAD_W-1:0]     pad_reg, pad_next;
    logic [SAMPLE_W-1:0]  sample_reg, sample_next;
    entry_t               wb_reg, wb_next;
    logic [1:0]           ev_num_reg, ev_num_next;
    btn_t                 ev0_reg, ev0_next;
    btn_t                 ev1_reg, ev1_next;
    btn_t                 out_kind_reg, out_kind_next;
    logic                 out_last_reg, out_last_next;
    logic                 pend_reg, pend_next;

    logic                 in_acc;
    logic                 pad_ok;
    entry_t               rd_data;
    logic                 wr_en;
    entry_t               wr_data;
    logic                 div_start;
    logic                 div_done;
    logic [SUM_W-1:0]     quotient;

    // evaluation of the entry read back
    logic                 untouched;
    logic [SUM_W-1:0]     sum_inc;
    logic [CNT_W-1:0]     cnt_inc;
    logic                 recal;
    btn_t                 btn_nx;
    logic [1:0]           ev_num;
    btn_t                 ev0, ev1;
    entry_t               upd;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign pad_ok    = 32'(s_tdata[PAD_W-1:0]) < 32'(NUM_PADS);

    tbet_state_mem u_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_acc),
        .rd_addr (s_tdata[PAD_W-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (pad_reg),
        .wr_data (wr_data)
    );

    tbet_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (upd.sum),
        .divisor  ((cnt_inc == '0) ? CNT_W'(1) : cnt_inc),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        untouched = sample_reg > rd_data.threshold;
        sum_inc   = rd_data.sum + SUM_W'(sample_reg);
        cnt_inc   = rd_data.count + 1'b1;
        recal     = untouched && (cnt_inc >= window_reg);

        btn_nx = rd_data.btn;
        ev_num = 2'd0;
        ev0    = BTN_IDLE;
        ev1    = BTN_KEY_DOWN;
        case (rd_data.btn)
            BTN_IDLE:
            begin
                if (!untouched)
                begin
                    btn_nx = BTN_KEY_DOWN;
                    ev_num = 2'd1;
                    ev0    = BTN_KEY_DOWN;
                end
            end
            BTN_KEY_DOWN:
            begin
                if (untouched)
                begin
                    btn_nx = BTN_KEY_UP;
                    ev_num = 2'd1;
                    ev0    = BTN_KEY_UP;
                end
            end
            BTN_KEY_UP:
            begin
                ev0 = BTN_CLICK;
                if (untouched)
                begin
                    btn_nx = BTN_CLICK;
                    ev_num = 2'd1;
                end
                else
                begin
                    btn_nx = BTN_KEY_DOWN;
                    ev_num = 2'd2;
                end
            end
            default:
            begin
                ev0 = BTN_IDLE;
                if (untouched)
                begin
                    btn_nx = BTN_IDLE;
                    ev_num = 2'd1;
                end
                else
                begin
                    btn_nx = BTN_KEY_DOWN;
                    ev_num = 2'd2;
                end
            end
        endcase

        upd.threshold = rd_data.threshold;
        upd.sum       = untouched ? sum_inc : '0;
        upd.count     = untouched ? cnt_inc : '0;
        upd.btn       = btn_nx;
    end

    always_comb
    begin
        state_next    = state_reg;
        window_next   = window_reg;
        cmd_next      = cmd_reg;
        pad_next      = pad_reg;
        sample_next   = sample_reg;
        wb_next       = wb_reg;
        ev_num_next   = ev_num_reg;
        ev0_next      = ev0_reg;
        ev1_next      = ev1_reg;
        out_kind_next = out_kind_reg;
        out_last_next = out_last_reg;
        pend_next     = pend_reg;
        wr_en         = 1'b0;
        wr_data       = upd;
        div_start     = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            window_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && pad_ok)
                begin
                    cmd_next    = s_tuser;
                    pad_next    = s_tdata[PAD_W-1:0];
                    sample_next = s_tdata[PAD_W+SAMPLE_W-1:PAD_W];
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                ev_num_next   = ev_num;
                ev0_next      = ev0;
                ev1_next      = ev1;
                out_kind_next = ev0;
                out_last_next = (ev_num == 2'd1);
                pend_next     = (ev_num == 2'd2);
                if (!cmd_reg)
                begin
                    // baseline: fresh threshold, cleared sums, button idle
                    wr_en             = 1'b1;
                    wr_data.threshold = sample_reg >> 1;
                    wr_data.sum       = '0;
                    wr_data.count     = '0;
                    wr_data.btn       = BTN_IDLE;
                    state_next        = ST_IDLE;
                end
                else if (recal)
                begin
                    div_start     = 1'b1;
                    wb_next       = upd;
                    wb_next.sum   = '0;
                    wb_next.count = '0;
                    state_next    = ST_DIV;
                end
                else
                begin
                    wr_en      = 1'b1;
                    state_next = (ev_num == 2'd0) ? ST_IDLE : ST_OUT;
                end
            end
            ST_DIV:
            begin
                wr_data = wb_reg;
                if (div_done)
                begin
                    wr_en             = 1'b1;
                    wr_data.threshold = quotient[SAMPLE_W:1];
                    state_next        = (ev_num_reg == 2'd0) ? ST_IDLE : ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    if (pend_reg)
                    begin
                        out_kind_next = ev1_reg;
                        out_last_next = 1'b1;
                        pend_next     = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            window_reg   <= WINDOW_RESET;
            pend_reg     <= 1'b0;
            cmd_reg      <= 1'b0;
            pad_reg      <= '0;
            sample_reg   <= '0;
            wb_reg       <= '0;
            ev_num_reg   <= '0;
            ev0_reg      <= BTN_IDLE;
            ev1_reg      <= BTN_IDLE;
            out_kind_reg <= BTN_IDLE;
            out_last_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            window_reg   <= window_next;
            pend_reg     <= pend_next;
            cmd_reg      <= cmd_next;
            pad_reg      <= pad_next;
            sample_reg   <= sample_next;
            wb_reg       <= wb_next;
            ev_num_reg   <= ev_num_next;
            ev0_reg      <= ev0_next;
            ev1_reg      <= ev1_next;
            out_kind_reg <= out_kind_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {4'b0, pad_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- design/tbet_state_mem.sv -----
// Per-pad state memory: one write port, one registered read port.
// Entries never written since reset read as all zero. Depends on tbet_pkg.
module tbet_state_mem
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [tbet_pkg::PAD_W-1:0] rd_addr,
    output tbet_pkg::entry_t          rd_data,
    input  logic                      wr_en,
    input  logic [tbet_pkg::PAD_W-1:0] wr_addr,
    input  tbet_pkg::entry_t          wr_data
);
    import tbet_pkg::*;

    entry_t               mem_ram [NUM_PADS];
    logic [NUM_PADS-1:0]  valid_reg;
    entry_t               rd_data_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_ram[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_ram[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ----- design/tbet_div.sv -----
// Restoring divider, one quotient bit per cycle: sum / count.
// Depends on tbet_pkg.
module tbet_div
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [tbet_pkg::SUM_W-1:0] dividend,
    input  logic [tbet_pkg::CNT_W-1:0] divisor,
    output logic                      done,
    output logic [tbet_pkg::SUM_W-1:0] quotient
);
    import tbet_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]     dvs_reg, dvs_next;
    logic [CNT_W:0]       rem_sh;
    logic                 ge;

    assign rem_sh = {rem_reg, quo_reg[SUM_W-1]};
    assign ge     = rem_sh >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(SUM_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the top bit drops
            rem_next = ge ? CNT_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[CNT_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- tb/sv/tbet_tb_pkg.sv -----
`timescale 1ns / 1ps
// Testbench-side codes and the expected event word for the touch tracker bench.
// Depends on tbet_pkg (btn_t); used by the checker and the testbench top.
package tbet_tb_pkg;

    import tbet_pkg::*;

    localparam logic CMD_BASELINE = 1'b0;
    localparam logic CMD_SAMPLE   = 1'b1;

    typedef struct packed {
        logic [PAD_W-1:0] pad;
        btn_t             kind;
        logic             closing;
    } event_word_t;

endpackage

// ----- tb/sv/tbet_event_checker.sv -----
`timescale 1ns / 1ps
// Event checker: tracks thresholds, calibration and button states per pad,
// predicts event words and compares them with the block's output stream.
// Depends on tbet_pkg and tbet_tb_pkg.
module tbet_event_checker
    import tbet_pkg::*;
    import tbet_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);

    logic [SAMPLE_W-1:0] pad_thr   [NUM_PADS];
    logic [SUM_W-1:0]    quiet_sum [NUM_PADS];
    logic [CNT_W-1:0]    quiet_cnt [NUM_PADS];
    btn_t                btn_of    [NUM_PADS];
    logic [CNT_W-1:0]    window;
    event_word_t         events_due[$];
    int                  fails;

    task automatic report_mismatch(input string what, input int got, input int want);
        fails++;
        $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    task automatic push_event(input logic [PAD_W-1:0] pad, input btn_t kind,
                              input logic closing);
        event_word_t ev;
        ev.pad     = pad;
        ev.kind    = kind;
        ev.closing = closing;
        events_due.push_back(ev);
    endtask

    // Threshold tracking and button machine for one accepted input word
    task automatic track_touch(input logic cmd, input logic [PAD_W-1:0] pad,
                               input logic [SAMPLE_W-1:0] level);
        logic             untouched;
        logic [CNT_W-1:0] divisor;
        if (cmd == CMD_BASELINE)
        begin
            pad_thr[pad]   = level >> 1;
            quiet_sum[pad] = '0;
            quiet_cnt[pad] = '0;
            btn_of[pad]    = BTN_IDLE;
            return;
        end
        untouched = level > pad_thr[pad];
        if (untouched)
        begin
            quiet_sum[pad] = quiet_sum[pad] + SUM_W'(level);
            quiet_cnt[pad] = quiet_cnt[pad] + 1'b1;
            // a window of zero still recalibrates on every untouched word
            if (quiet_cnt[pad] >= window)
            begin
                divisor        = (quiet_cnt[pad] != '0) ? quiet_cnt[pad] : CNT_W'(1);
                pad_thr[pad]   = SAMPLE_W'((quiet_sum[pad] / divisor) >> 1);
                quiet_sum[pad] = '0;
                quiet_cnt[pad] = '0;
            end
        end
        else
        begin
            quiet_sum[pad] = '0;
            quiet_cnt[pad] = '0;
        end
        case (btn_of[pad])
            BTN_IDLE:
                if (!untouched)
                begin
                    btn_of[pad] = BTN_KEY_DOWN;
                    push_event(pad, BTN_KEY_DOWN, 1'b1);
                end
            BTN_KEY_DOWN:
                if (untouched)
                begin
                    btn_of[pad] = BTN_KEY_UP;
                    push_event(pad, BTN_KEY_UP, 1'b1);
                end
            BTN_KEY_UP:
                if (untouched)
                begin
                    btn_of[pad] = BTN_CLICK;
                    push_event(pad, BTN_CLICK, 1'b1);
                end
                else
                begin
                    btn_of[pad] = BTN_KEY_DOWN;
                    push_event(pad, BTN_CLICK, 1'b0);
                    push_event(pad, BTN_KEY_DOWN, 1'b1);
                end
            default:
                if (untouched)
                begin
                    btn_of[pad] = BTN_IDLE;
                    push_event(pad, BTN_IDLE, 1'b1);
                end
                else
                begin
                    btn_of[pad] = BTN_KEY_DOWN;
                    push_event(pad, BTN_IDLE, 1'b0);
                    push_event(pad, BTN_KEY_DOWN, 1'b1);
                end
        endcase
    endtask

    task automatic check_event();
        event_word_t want;
        if (events_due.size() == 0)
        begin
            report_mismatch("unexpected event word, pad", m_tdata, -1);
            return;
        end
        want = events_due.pop_front();
        if (m_tdata != {4'b0, want.pad})
            report_mismatch("event_pad", m_tdata, want.pad);
        if (m_tuser != want.kind)
            report_mismatch("event_kind", m_tuser, want.kind);
        if (m_tlast != want.closing)
            report_mismatch("last", m_tlast, want.closing);
    endtask

    // Outputs update by NBA so the top always reads last cycle's view
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PADS; i++)
            begin
                pad_thr[i]   = '0;
                quiet_sum[i] = '0;
                quiet_cnt[i] = '0;
                btn_of[i]    = BTN_IDLE;
            end
            window = WINDOW_RESET;
            events_due.delete();
            fails = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // an output word at this edge always belongs to an earlier input word
            if (m_tvalid && m_tready)
                check_event();
            if (cfg_valid && cfg_ready)
                window = cfg_data;
            if (s_tvalid && s_tready)
                track_touch(s_tuser, s_tdata[3:0], s_tdata[19:4]);
            fail_count <= fails;
            pending    <= events_due.size();
        end
    end

endmodule

// ----- tb/sv/tb_touch_button_event_tracker_core.sv -----
`timescale 1ns / 1ps
// Testbench top for touch_button_event_tracker_core: clock, reset, stimulus
// and verdict. Depends on tbet_pkg, tbet_tb_pkg and tbet_event_checker.
module tb_touch_button_event_tracker_core;

    import tbet_pkg::*;
    import tbet_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int NUM_PHASES    = 8;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int stall_left  = 0;
    bit quiet       = 1'b0;

    touch_button_event_tracker_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    tbet_event_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_touch_button_event_tracker_core NOT OK");
            $finish;
        end
    end

    // Sink stalls: mostly short, now and then long, none in quiet phases
    always @(posedge clk)
    begin
        int r;
        r = $urandom_range(0, 99);
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (quiet || r < 70)
            m_tready <= 1'b1;
        else
        begin
            stall_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(9, 39);
            m_tready <= 1'b0;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_word(input logic cmd, input logic [3:0] pad, input logic [15:0] level);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, level, pad};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Window writes only once the block has drained and settled
    task automatic set_window(input logic [7:0] w);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed touch/release traffic, with stray baselines and noise
    task automatic send_random(input int n_pads, input logic [3:0] pad_flip,
                               input int touch_pct);
        logic [3:0] pad;
        int         r;
        pad = 4'($urandom_range(0, n_pads - 1)) ^ pad_flip;
        r   = $urandom_range(0, 99);
        if (r < 4)
            send_word(CMD_BASELINE, pad, 16'($urandom_range(40000, 65535)));
        else if (r < 9)
            send_word(1'($urandom), 4'($urandom), 16'($urandom));
        else if ($urandom_range(0, 99) < touch_pct)
            send_word(CMD_SAMPLE, pad, 16'($urandom_range(0, 9000)));
        else
            send_word(CMD_SAMPLE, pad, 16'($urandom_range(45000, 65535)));
    endtask

    initial
    begin
        logic [7:0] windows [NUM_PHASES];
        int         n_items;
        int         n_pads;
        int         touch_pct;
        logic [3:0] pad_flip;

        windows = '{8'd1, 8'd2, 8'd5, 8'd255, 8'd100, 8'd0, 8'd3, 8'd255};
        windows[NUM_PHASES-1] = 8'($urandom_range(6, 254));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Threshold zero after reset: zero reads touched, one reads untouched
        quiet = 1'b1;
        send_word(CMD_SAMPLE, 4'd0, 16'd0);
        send_word(CMD_SAMPLE, 4'd0, 16'd1);
        send_word(CMD_SAMPLE, 4'd0, 16'd0);
        send_word(CMD_SAMPLE, 4'd0, 16'hFFFF);
        send_word(CMD_SAMPLE, 4'd0, 16'hFFFF);
        send_word(CMD_SAMPLE, 4'd0, 16'hFFFF);
        quiet = 1'b0;
        // sample equal to threshold counts as touched, one above as untouched
        send_word(CMD_BASELINE, 4'd15, 16'hFFFF);
        send_word(CMD_SAMPLE, 4'd15, 16'd32767);
        send_word(CMD_SAMPLE, 4'd15, 16'd32768);
        send_word(CMD_SAMPLE, 4'd15, 16'd32768);
        send_word(CMD_SAMPLE, 4'd15, 16'd32767);
        // baseline from key down returns to idle silently
        send_word(CMD_BASELINE, 4'd15, 16'd0);
        send_word(CMD_SAMPLE, 4'd15, 16'd0);
        // window lowered below a running count: recalibrates on the next word
        send_word(CMD_BASELINE, 4'd5, 16'd2000);
        repeat (6) send_word(CMD_SAMPLE, 4'd5, 16'($urandom_range(1001, 65535)));
        set_window(8'd3);
        send_word(CMD_SAMPLE, 4'd5, 16'($urandom_range(1001, 65535)));
        set_window(8'd0);
        send_word(CMD_SAMPLE, 4'd5, 16'($urandom_range(40000, 65535)));
        send_word(CMD_SAMPLE, 4'd5, 16'($urandom_range(0, 1000)));

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            set_window(windows[ph]);
            quiet    = (ph == 2) || ($urandom_range(0, 3) == 0);
            pad_flip = 4'($urandom);
            if (windows[ph] == 8'd255)
            begin
                // one pad, nearly always untouched, so the full window closes
                n_items   = 320;
                n_pads    = 1;
                touch_pct = 1;
            end
            else
            begin
                n_items   = 105;
                n_pads    = $urandom_range(1, 16);
                touch_pct = 30;
            end
            repeat (n_items) send_random(n_pads, pad_flip, touch_pct);
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_touch_button_event_tracker_core OK");
        else
            $display("tb_touch_button_event_tracker_core NOT OK");
        $finish;
    end

endmodule
